// ===== sv/lobm_pkg.sv =====
// Shared types and codes of the limit order book matcher.
`default_nettype none
package lobm_pkg;

    // Input actions
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;

    // Decoded operations
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_DEPTH  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_FILL      = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_DONE      = 3'd2;
    localparam logic [2:0] KIND_CANCEL_OK = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd4;
    localparam logic [2:0] KIND_DEPTH     = 3'd5;
    localparam logic [2:0] KIND_FULL      = 3'd6;
    localparam logic [2:0] KIND_DUP       = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] ident;
        logic        side;
        logic        order_kind;
        logic [15:0] price;
        logic [31:0] quantity;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] maker_id;
        logic [31:0] taker_id;
        logic [15:0] trade_price;
        logic [31:0] amount;
        logic        last;
        logic [15:0] top_bid;
        logic        top_bid_valid;
        logic [15:0] top_ask;
        logic        top_ask_valid;
        logic [15:0] spread;
        logic        spread_valid;
    } rsp_t;

    // Classified request between front and back
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ident;
        logic        side;
        logic        market;
        logic [15:0] price;
        logic [31:0] quantity;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    // One resting order slot
    typedef struct packed {
        logic [31:0] ident;
        logic        side;
        logic [15:0] price;
        logic [31:0] quantity;
        logic [31:0] arrival;
    } slot_t;

    // One buffered fill
    typedef struct packed {
        logic [31:0] maker_id;
        logic [15:0] price;
        logic [31:0] amount;
    } fill_t;

endpackage
`default_nettype wire

// ===== sv/lobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/lobm_front.sv =====
// Front end: accept requests, classify them and queue them for the engine.
`default_nettype none
module lobm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lobm_pkg::req_t    request,
    output lobm_pkg::cmd_chan_t    chan,
    input  wire logic              take
);

    lobm_pkg::cmd_t q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    lobm_pkg::cmd_t cls;

    // Classify the request; unused action decodes as depth query
    always_comb
    begin
        cls.ident    = request.ident;
        cls.side     = request.side;
        cls.market   = request.order_kind;
        cls.price    = request.price;
        cls.quantity = request.quantity;
        if (request.action == lobm_pkg::ACT_ADD)
        begin
            cls.op = lobm_pkg::OP_ADD;
        end
        else if (request.action == lobm_pkg::ACT_CANCEL)
        begin
            cls.op = lobm_pkg::OP_CANCEL;
        end
        else
        begin
            cls.op = lobm_pkg::OP_DEPTH;
        end
    end

    assign full       = cnt_reg[1];
    assign do_push    = push && !full;
    assign do_pop     = take && (cnt_reg != 2'd0);
    assign chan.valid = cnt_reg != 2'd0;
    assign chan.cmd   = q_reg[rp_reg];

    // Advance pointers and count
    always_comb
    begin
        wp_next  = do_push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lobm_engine.sv =====
// Back end: book storage, slot scans, matching, result buffering and drain.
`default_nettype none
module lobm_engine #(
    parameter int BOOK_ORDERS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lobm_pkg::cmd_chan_t chan,
    output logic                     take,
    output logic                     empty,
    input  wire logic                pop,
    output lobm_pkg::rsp_t           result
);

    localparam int IW = $clog2(BOOK_ORDERS);
    localparam int CW = $clog2(BOOK_ORDERS + 1);
    localparam int SW = $bits(lobm_pkg::slot_t);
    localparam int FW = $bits(lobm_pkg::fill_t);
    localparam logic [CW-1:0] LAST_CNT = CW'(BOOK_ORDERS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_POST  = 3'd2;
    localparam logic [2:0] S_DREAD = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DWAIT = 3'd5;

    logic [2:0]       state_reg, state_next;
    lobm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]      rem_reg, rem_next;
    logic             first_reg, first_next;
    logic             final_reg, final_next;
    logic [CW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic             pv_reg, pv_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    found_idx_reg, found_idx_next;
    logic             free_ok_reg, free_ok_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic             mk_ok_reg, mk_ok_next;
    logic [IW-1:0]    mk_idx_reg, mk_idx_next;
    lobm_pkg::slot_t  mk_reg, mk_next;
    logic [31:0]      mk_age_reg, mk_age_next;
    logic [31:0]      depth_reg, depth_next;
    logic             bid_ok_reg, bid_ok_next;
    logic [15:0]      bid_reg, bid_next;
    logic             ask_ok_reg, ask_ok_next;
    logic [15:0]      ask_reg, ask_next;
    logic [BOOK_ORDERS-1:0] used_reg, used_next;
    logic [31:0]      arrival_reg, arrival_next;
    logic [CW-1:0]    fill_cnt_reg, fill_cnt_next;
    logic [CW-1:0]    d_cnt_reg, d_cnt_next;
    logic [2:0]       st_kind_reg, st_kind_next;
    logic [31:0]      st_amt_reg, st_amt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    logic [2:0]       out_kind_reg, out_kind_next;
    logic [31:0]      out_maker_reg, out_maker_next;
    logic [31:0]      out_taker_reg, out_taker_next;
    logic [15:0]      out_price_reg, out_price_next;
    logic [31:0]      out_amt_reg, out_amt_next;

    logic             slot_we;
    logic [IW-1:0]    slot_waddr, slot_raddr;
    lobm_pkg::slot_t  slot_wdata, slot_rdata;
    logic             fb_we;
    logic [IW-1:0]    fb_waddr, fb_raddr;
    lobm_pkg::fill_t  fb_wdata, fb_rdata;

    logic             u;
    logic [31:0]      age;
    logic             better;
    logic [32:0]      dsum;
    logic             price_ok;
    logic             maker_done;
    logic [31:0]      fill_amt;
    logic [31:0]      mk_left;
    logic [31:0]      rem_left;
    logic             sp_ok;

    lobm_ram #(.WIDTH(SW), .DEPTH(BOOK_ORDERS)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    lobm_ram #(.WIDTH(FW), .DEPTH(BOOK_ORDERS)) u_fills (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    // Per-entry scan terms
    always_comb
    begin
        u    = used_reg[pidx_reg];
        age  = arrival_reg - slot_rdata.arrival;
        dsum = {1'b0, depth_reg} + {1'b0, slot_rdata.quantity};
        if (!mk_ok_reg)
        begin
            better = 1'b1;
        end
        else if (slot_rdata.price != mk_reg.price)
        begin
            better = cmd_reg.side ? (slot_rdata.price > mk_reg.price)
                                  : (slot_rdata.price < mk_reg.price);
        end
        else
        begin
            better = age > mk_age_reg;
        end
    end

    // Match terms for the chosen maker
    always_comb
    begin
        price_ok   = cmd_reg.market ||
                     (cmd_reg.side ? (mk_reg.price >= cmd_reg.price)
                                   : (mk_reg.price <= cmd_reg.price));
        maker_done = mk_reg.quantity <= rem_reg;
        fill_amt   = maker_done ? mk_reg.quantity : rem_reg;
        mk_left    = maker_done ? 32'd0 : mk_reg.quantity - rem_reg;
        rem_left   = maker_done ? rem_reg - mk_reg.quantity : 32'd0;
    end

    assign take       = (state_reg == S_IDLE) && chan.valid;
    assign slot_raddr = scan_cnt_reg[IW-1:0];
    assign fb_raddr   = d_cnt_reg[IW-1:0];
    assign fb_waddr   = fill_cnt_reg[IW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        scan_cnt_next  = scan_cnt_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        mk_ok_next     = mk_ok_reg;
        mk_idx_next    = mk_idx_reg;
        mk_next        = mk_reg;
        mk_age_next    = mk_age_reg;
        depth_next     = depth_reg;
        bid_ok_next    = bid_ok_reg;
        bid_next       = bid_reg;
        ask_ok_next    = ask_ok_reg;
        ask_next       = ask_reg;
        used_next      = used_reg;
        arrival_next   = arrival_reg;
        fill_cnt_next  = fill_cnt_reg;
        d_cnt_next     = d_cnt_reg;
        st_kind_next   = st_kind_reg;
        st_amt_next    = st_amt_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_kind_next  = out_kind_reg;
        out_maker_next = out_maker_reg;
        out_taker_next = out_taker_reg;
        out_price_next = out_price_reg;
        out_amt_next   = out_amt_reg;
        slot_we        = 1'b0;
        slot_waddr     = mk_idx_reg;
        slot_wdata     = mk_reg;
        fb_we          = 1'b0;
        fb_wdata.maker_id = mk_reg.ident;
        fb_wdata.price    = mk_reg.price;
        fb_wdata.amount   = fill_amt;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the next request
                if (chan.valid)
                begin
                    cmd_next      = chan.cmd;
                    rem_next      = chan.cmd.quantity;
                    first_next    = 1'b1;
                    final_next    = 1'b0;
                    fill_cnt_next = '0;
                    d_cnt_next    = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue the next slot read
                if (scan_cnt_reg != LAST_CNT)
                begin
                    pv_next       = 1'b1;
                    pidx_next     = scan_cnt_reg[IW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = S_POST;
                end
                // Fold the slot read last cycle into the scan results
                if (pv_reg)
                begin
                    if (u && slot_rdata.ident == cmd_reg.ident && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = pidx_reg;
                    end
                    if (!u && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (u && slot_rdata.side != cmd_reg.side && better)
                    begin
                        mk_ok_next  = 1'b1;
                        mk_idx_next = pidx_reg;
                        mk_next     = slot_rdata;
                        mk_age_next = age;
                    end
                    if (u && slot_rdata.side == cmd_reg.side
                          && slot_rdata.price == cmd_reg.price)
                    begin
                        depth_next = dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
                    end
                    if (u && !slot_rdata.side)
                    begin
                        if (!bid_ok_reg || slot_rdata.price > bid_reg)
                        begin
                            bid_next = slot_rdata.price;
                        end
                        bid_ok_next = 1'b1;
                    end
                    if (u && slot_rdata.side)
                    begin
                        if (!ask_ok_reg || slot_rdata.price < ask_reg)
                        begin
                            ask_next = slot_rdata.price;
                        end
                        ask_ok_next = 1'b1;
                    end
                end
            end
            S_POST:
            begin
                if (final_reg)
                begin
                    state_next = S_DREAD;
                end
                else
                begin
                    final_next = 1'b1;
                    first_next = 1'b0;
                    state_next = S_SCAN;
                    unique case (cmd_reg.op)
                        lobm_pkg::OP_ADD:
                        begin
                            priority if (first_reg && found_reg)
                            begin
                                st_kind_next = lobm_pkg::KIND_DUP;
                                st_amt_next  = cmd_reg.quantity;
                            end
                            else if (rem_reg != 32'd0 && mk_ok_reg && price_ok)
                            begin
                                // Fill against the chosen maker and rescan
                                final_next    = 1'b0;
                                fb_we         = 1'b1;
                                fill_cnt_next = fill_cnt_reg + CW'(1);
                                slot_we       = 1'b1;
                                slot_wdata.quantity = mk_left;
                                if (maker_done)
                                begin
                                    used_next[mk_idx_reg] = 1'b0;
                                end
                                rem_next = rem_left;
                            end
                            else if (rem_reg != 32'd0 && !cmd_reg.market)
                            begin
                                st_amt_next = rem_reg;
                                if (free_ok_reg)
                                begin
                                    // Rest the remainder in the lowest free slot
                                    slot_we             = 1'b1;
                                    slot_waddr          = free_idx_reg;
                                    slot_wdata.ident    = cmd_reg.ident;
                                    slot_wdata.side     = cmd_reg.side;
                                    slot_wdata.price    = cmd_reg.price;
                                    slot_wdata.quantity = rem_reg;
                                    slot_wdata.arrival  = arrival_reg;
                                    used_next[free_idx_reg] = 1'b1;
                                    arrival_next  = arrival_reg + 32'd1;
                                    st_kind_next  = lobm_pkg::KIND_RESTED;
                                end
                                else
                                begin
                                    st_kind_next = lobm_pkg::KIND_FULL;
                                end
                            end
                            else
                            begin
                                st_kind_next = lobm_pkg::KIND_DONE;
                                st_amt_next  = rem_reg;
                            end
                        end
                        lobm_pkg::OP_CANCEL:
                        begin
                            st_amt_next = 32'd0;
                            if (found_reg)
                            begin
                                used_next[found_idx_reg] = 1'b0;
                                st_kind_next = lobm_pkg::KIND_CANCEL_OK;
                            end
                            else
                            begin
                                st_kind_next = lobm_pkg::KIND_UNKNOWN;
                            end
                        end
                        default:
                        begin
                            st_kind_next = lobm_pkg::KIND_DEPTH;
                            st_amt_next  = depth_reg;
                        end
                    endcase
                end
            end
            S_DREAD:
            begin
                // Read the next buffered fill or present the status
                if (d_cnt_reg != fill_cnt_reg)
                begin
                    state_next = S_DLOAD;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_kind_next  = st_kind_reg;
                    out_maker_next = 32'd0;
                    out_taker_next = 32'd0;
                    out_price_next = 16'd0;
                    out_amt_next   = st_amt_reg;
                    state_next     = S_DWAIT;
                end
            end
            S_DLOAD:
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b0;
                out_kind_next  = lobm_pkg::KIND_FILL;
                out_maker_next = fb_rdata.maker_id;
                out_taker_next = cmd_reg.ident;
                out_price_next = fb_rdata.price;
                out_amt_next   = fb_rdata.amount;
                state_next     = S_DWAIT;
            end
            S_DWAIT:
            begin
                // Hold the result until it is taken
                if (pop)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_cnt_next = d_cnt_reg + CW'(1);
                        state_next = S_DREAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Clear scan results when a scan begins
        if (state_next == S_SCAN && state_reg != S_SCAN)
        begin
            scan_cnt_next = '0;
            found_next    = 1'b0;
            free_ok_next  = 1'b0;
            mk_ok_next    = 1'b0;
            depth_next    = 32'd0;
            bid_ok_next   = 1'b0;
            ask_ok_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            arrival_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            bid_ok_reg    <= 1'b0;
            ask_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            arrival_reg   <= arrival_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= pv_next;
            bid_ok_reg    <= bid_ok_next;
            ask_ok_reg    <= ask_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rem_reg       <= rem_next;
        first_reg     <= first_next;
        final_reg     <= final_next;
        scan_cnt_reg  <= scan_cnt_next;
        pidx_reg      <= pidx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_ok_reg   <= free_ok_next;
        free_idx_reg  <= free_idx_next;
        mk_ok_reg     <= mk_ok_next;
        mk_idx_reg    <= mk_idx_next;
        mk_reg        <= mk_next;
        mk_age_reg    <= mk_age_next;
        depth_reg     <= depth_next;
        bid_reg       <= bid_next;
        ask_reg       <= ask_next;
        fill_cnt_reg  <= fill_cnt_next;
        d_cnt_reg     <= d_cnt_next;
        st_kind_reg   <= st_kind_next;
        st_amt_reg    <= st_amt_next;
        out_last_reg  <= out_last_next;
        out_kind_reg  <= out_kind_next;
        out_maker_reg <= out_maker_next;
        out_taker_reg <= out_taker_next;
        out_price_reg <= out_price_next;
        out_amt_reg   <= out_amt_next;
    end

    // Drive the result with the book summary
    assign sp_ok = bid_ok_reg && ask_ok_reg && (ask_reg >= bid_reg);
    assign empty = !out_valid_reg;

    always_comb
    begin
        result.kind          = out_kind_reg;
        result.maker_id      = out_maker_reg;
        result.taker_id      = out_taker_reg;
        result.trade_price   = out_price_reg;
        result.amount        = out_amt_reg;
        result.last          = out_last_reg;
        result.top_bid       = bid_ok_reg ? bid_reg : 16'd0;
        result.top_bid_valid = bid_ok_reg;
        result.top_ask       = ask_ok_reg ? ask_reg : 16'd0;
        result.top_ask_valid = ask_ok_reg;
        result.spread        = sp_ok ? ask_reg - bid_reg : 16'd0;
        result.spread_valid  = sp_ok;
    end

endmodule
`default_nettype wire

// ===== sv/limit_order_book_matcher.sv =====
// Top level of the price-time priority limit order book matcher.
`default_nettype none
// Requests enter through a two-entry queue and are carried out one at a time.
// Each pass over the book reads one slot per cycle from the slot RAM. An add
// takes one pass, one more per fill, and a final pass for the book summary;
// cancel and depth take two passes. Results of a request then drain with pop
// held high, the buffered fills first and the closing status last, each
// carrying the best bid, best ask and spread after the whole request. No
// clearing pass is needed after reset.
module limit_order_book_matcher #(
    parameter int BOOK_ORDERS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lobm_pkg::req_t request,
    output logic                empty,
    input  wire logic           pop,
    output lobm_pkg::rsp_t      result
);

    lobm_pkg::cmd_chan_t chan;
    logic                take;

    lobm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .chan    (chan),
        .take    (take)
    );

    lobm_engine #(.BOOK_ORDERS(BOOK_ORDERS)) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .chan   (chan),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire
